FILE: design/assert_macros.svh
// Assertion macros used by the checker of the line position PID block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lpp_pkg.sv
// Types and constants shared by the line position PID block.
`default_nettype none

package lpp_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int READ_W       = 12;
    localparam int GAIN_W       = 16;
    localparam int MAP_W        = 10;
    localparam int ERR_W        = 14;
    localparam int CORR_W       = 32;
    localparam int WSUM_W       = 14;
    localparam int TOTAL_W      = 12;
    localparam int FRAC_W       = 8;
    localparam int MAP_NUM_W    = 22;
    localparam int CENT_NUM_W   = TOTAL_W + FRAC_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [MAP_NUM_W-1:0]    MAP_TOP    = 22'd1000;
    localparam logic [MAP_W-1:0]        MAP_FULL   = 10'd1000;
    localparam logic [MAP_W-1:0]        LOST_LEVEL = 10'd400;
    localparam logic [ERR_W-1:0]        SCALE_TEN  = 14'd10;
    localparam logic signed [ERR_W-1:0] LOST_ERROR = 14'sd6400;
    localparam logic signed [ERR_W-1:0] SUM_LIMIT  = 14'sd7680;

    // Centroid weights, leftmost sensor first
    localparam logic signed [WSUM_W-1:0] LINE_WEIGHTS [SENSOR_COUNT] =
        '{14'sd3, 14'sd1, -14'sd1, -14'sd3};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_CLAMP_LOW  = 3'd3,
        REG_CLAMP_HIGH = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
    } gains_t;

    typedef struct packed {
        logic [READ_W-1:0] clamp_low;
        logic [READ_W-1:0] clamp_high;
    } margins_t;

    localparam gains_t GAINS_RESET = '{
        prop_gain:  16'd2048,
        integ_gain: 16'd0,
        deriv_gain: 16'd845
    };

    localparam margins_t MARGINS_RESET = '{
        clamp_low:  12'd400,
        clamp_high: 12'd2000
    };

    // Top-level sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LANES = 5'b00010,
        ST_MERGE = 5'b00100,
        ST_PID   = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

endpackage

`default_nettype wire

FILE: design/line_position_pid.sv
// Line position PID: four-lane sensor mapping, centroid merge and PID correction.
// Each transfer carries four raw 12-bit readings. Four lanes map them in parallel
// to 0..1000 with their own serial dividers, the merge stage forms the weighted
// centroid through a second serial divider, and the PID stage runs three
// multiply-accumulate steps on one shared multiplier. The next item is taken only
// after the two divider chains and the PID stage have run in series for the
// current one; one item is in the block at a time, and the next is accepted
// while a finished result still waits in the output register. Configuration writes
// are accepted every cycle and belong in idle periods only.
`default_nettype none

module line_position_pid (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lpp_pkg::READ_W-1:0]        sensor_zero,
    input  logic [lpp_pkg::READ_W-1:0]        sensor_one,
    input  logic [lpp_pkg::READ_W-1:0]        sensor_two,
    input  logic [lpp_pkg::READ_W-1:0]        sensor_three,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lpp_pkg::ERR_W-1:0]  track_error,
    output logic signed [lpp_pkg::CORR_W-1:0] steer_correction,
    output logic                              line_lost,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lpp_pkg::state_t   state_reg, state_next;
    lpp_pkg::gains_t   gains_reg, gains_next;
    lpp_pkg::margins_t margins_reg, margins_next;

    logic [lpp_pkg::READ_W-1:0] readings [lpp_pkg::SENSOR_COUNT];
    logic [lpp_pkg::MAP_W-1:0]  mapped   [lpp_pkg::SENSOR_COUNT];
    logic [lpp_pkg::SENSOR_COUNT-1:0] lane_done;

    logic                              in_take;
    logic                              merge_start;
    logic                              merge_done;
    logic signed [lpp_pkg::ERR_W-1:0]  merge_error;
    logic                              merge_lost;
    logic                              pid_start;
    logic                              pid_done;
    logic                              last_positive;
    logic signed [lpp_pkg::ERR_W-1:0]  pid_error;
    logic                              pid_lost;
    logic signed [lpp_pkg::CORR_W-1:0] pid_corr;
    logic                              out_load;
    logic                              out_valid_reg, out_valid_next;
    logic signed [lpp_pkg::ERR_W-1:0]  track_error_reg;
    logic signed [lpp_pkg::CORR_W-1:0] steer_correction_reg;
    logic                              line_lost_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != lpp_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;

    // Configuration register writes
    always_comb
    begin
        gains_next   = gains_reg;
        margins_next = margins_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (lpp_pkg::cfg_reg_t'(cfg_index))
                lpp_pkg::REG_PROP_GAIN:  gains_next.prop_gain    = cfg_data;
                lpp_pkg::REG_INTEG_GAIN: gains_next.integ_gain   = cfg_data;
                lpp_pkg::REG_DERIV_GAIN: gains_next.deriv_gain   = cfg_data;
                lpp_pkg::REG_CLAMP_LOW:
                    margins_next.clamp_low  = cfg_data[lpp_pkg::READ_W-1:0];
                lpp_pkg::REG_CLAMP_HIGH:
                    margins_next.clamp_high = cfg_data[lpp_pkg::READ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg   <= lpp_pkg::GAINS_RESET;
            margins_reg <= lpp_pkg::MARGINS_RESET;
        end
        else
        begin
            gains_reg   <= gains_next;
            margins_reg <= margins_next;
        end
    end

    // Sensor lanes
    assign readings[0] = sensor_zero;
    assign readings[1] = sensor_one;
    assign readings[2] = sensor_two;
    assign readings[3] = sensor_three;

    for (genvar g = 0; g < lpp_pkg::SENSOR_COUNT; g++)
    begin : g_lane
        lpp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (in_take),
            .reading (readings[g]),
            .margins (margins_reg),
            .done    (lane_done[g]),
            .mapped  (mapped[g])
        );
    end

    assign merge_start = (state_reg == lpp_pkg::ST_LANES) && (&lane_done);

    lpp_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (merge_start),
        .mapped        (mapped),
        .last_positive (last_positive),
        .done          (merge_done),
        .track_error   (merge_error),
        .line_lost     (merge_lost)
    );

    assign pid_start = (state_reg == lpp_pkg::ST_MERGE) && merge_done;

    lpp_pid u_pid (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (pid_start),
        .error_in         (merge_error),
        .lost_in          (merge_lost),
        .gains            (gains_reg),
        .done             (pid_done),
        .last_positive    (last_positive),
        .track_error      (pid_error),
        .line_lost        (pid_lost),
        .steer_correction (pid_corr)
    );

    // Result moves out once the output register is free or being emptied
    assign out_load = (state_reg == lpp_pkg::ST_FLUSH) && (!out_valid_reg || !out_stall);

    // Item sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpp_pkg::ST_IDLE:  if (in_take)      state_next = lpp_pkg::ST_LANES;
            lpp_pkg::ST_LANES: if (merge_start)  state_next = lpp_pkg::ST_MERGE;
            lpp_pkg::ST_MERGE: if (pid_start)    state_next = lpp_pkg::ST_PID;
            lpp_pkg::ST_PID:   if (pid_done)     state_next = lpp_pkg::ST_FLUSH;
            lpp_pkg::ST_FLUSH: if (out_load)     state_next = lpp_pkg::ST_IDLE;
            default:                             state_next = lpp_pkg::ST_IDLE;
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            track_error_reg      <= pid_error;
            steer_correction_reg <= pid_corr;
            line_lost_reg        <= pid_lost;
        end
    end

    assign out_valid        = out_valid_reg;
    assign track_error      = track_error_reg;
    assign steer_correction = steer_correction_reg;
    assign line_lost        = line_lost_reg;

endmodule

`default_nettype wire

FILE: design/lpp_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module lpp_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   partial;
    logic             fits;

    // One shift-and-subtract step per cycle
    always_comb
    begin
        partial   = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (partial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = numerator;
            rem_next  = '0;
            den_next  = denominator;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(partial - {1'b0, den_reg}) : partial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/lpp_lane.sv
// One sensor lane: clamp, offset, scale to 0..1000 through a serial divider.
`default_nettype none

module lpp_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpp_pkg::READ_W-1:0]  reading,
    input  lpp_pkg::margins_t           margins,
    output logic                        done,
    output logic [lpp_pkg::MAP_W-1:0]   mapped
);

    logic [lpp_pkg::READ_W-1:0]    clamped;
    logic [lpp_pkg::READ_W-1:0]    offset;
    logic [lpp_pkg::READ_W-1:0]    span;
    logic [lpp_pkg::MAP_NUM_W-1:0] scaled;
    logic [lpp_pkg::MAP_NUM_W-1:0] div_quo;
    logic                          degen;
    logic                          degen_reg;
    logic                          hit_reg;

    // Clamp to the margins and scale the offset by one thousand
    always_comb
    begin
        degen = (margins.clamp_high <= margins.clamp_low);
        if (reading < margins.clamp_low)
            clamped = margins.clamp_low;
        else if (reading > margins.clamp_high)
            clamped = margins.clamp_high;
        else
            clamped = reading;
        offset = clamped - margins.clamp_low;
        span   = margins.clamp_high - margins.clamp_low;
        scaled = lpp_pkg::MAP_NUM_W'(offset) * lpp_pkg::MAP_TOP;
    end

    // Empty or inverted margin window: plain threshold at clamp_low
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            degen_reg <= degen;
            hit_reg   <= (reading > margins.clamp_low);
        end
    end

    lpp_divider #(
        .NUM_W (lpp_pkg::MAP_NUM_W),
        .DEN_W (lpp_pkg::READ_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .numerator   (scaled),
        .denominator (span),
        .done        (done),
        .quotient    (div_quo)
    );

    // Outside the degenerate window the quotient never exceeds 1000
    assign mapped = degen_reg ? (hit_reg ? lpp_pkg::MAP_FULL : '0)
                              : div_quo[lpp_pkg::MAP_W-1:0];

endmodule

`default_nettype wire

FILE: design/lpp_merge.sv
// Merges the lanes: weighted centroid, line-lost test and scaled track error.
`default_nettype none

module lpp_merge (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lpp_pkg::MAP_W-1:0]        mapped [lpp_pkg::SENSOR_COUNT],
    input  logic                             last_positive,
    output logic                             done,
    output logic signed [lpp_pkg::ERR_W-1:0] track_error,
    output logic                             line_lost
);

    logic signed [lpp_pkg::WSUM_W-1:0]  wsum;
    logic signed [lpp_pkg::WSUM_W-1:0]  wabs;
    logic [lpp_pkg::TOTAL_W-1:0]        total;
    logic                               seen;
    logic [lpp_pkg::CENT_NUM_W-1:0]     numerator;
    logic [lpp_pkg::CENT_NUM_W-1:0]     div_quo;
    logic                               div_done;
    logic [lpp_pkg::ERR_W-1:0]          err_mag;
    logic signed [lpp_pkg::ERR_W-1:0]   err_val;
    logic                               neg_reg;
    logic                               zero_reg;
    logic                               lost_reg;
    logic signed [lpp_pkg::ERR_W-1:0]   err_reg;
    logic                               done_reg;

    // Weighted sum and plain sum over the lanes
    always_comb
    begin
        wsum = '0;
        total = '0;
        seen = 1'b0;
        for (int i = 0; i < lpp_pkg::SENSOR_COUNT; i++)
        begin
            wsum = wsum + lpp_pkg::LINE_WEIGHTS[i] *
                   $signed({{(lpp_pkg::WSUM_W - lpp_pkg::MAP_W){1'b0}}, mapped[i]});
            total = total + lpp_pkg::TOTAL_W'(mapped[i]);
            if (mapped[i] > lpp_pkg::LOST_LEVEL)
                seen = 1'b1;
        end
        wabs      = wsum[lpp_pkg::WSUM_W-1] ? -wsum : wsum;
        numerator = {wabs[lpp_pkg::TOTAL_W-1:0], {lpp_pkg::FRAC_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= wsum[lpp_pkg::WSUM_W-1];
            zero_reg <= (total == '0);
            lost_reg <= !seen;
        end
    end

    // Magnitude divide, sign restored afterwards: truncates toward zero
    lpp_divider #(
        .NUM_W (lpp_pkg::CENT_NUM_W),
        .DEN_W (lpp_pkg::TOTAL_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .numerator   (numerator),
        .denominator (total),
        .done        (div_done),
        .quotient    (div_quo)
    );

    // Scale by ten and restore the sign, then substitute the lost-line error, or zero for a zero total
    always_comb
    begin
        err_mag = lpp_pkg::ERR_W'(div_quo[lpp_pkg::MAP_W-1:0]) * lpp_pkg::SCALE_TEN;
        if (lost_reg)
            err_val = last_positive ? lpp_pkg::LOST_ERROR : -lpp_pkg::LOST_ERROR;
        else if (zero_reg)
            err_val = '0;
        else if (neg_reg)
            err_val = -$signed(err_mag);
        else
            err_val = $signed(err_mag);
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
            err_reg <= err_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_done;
    end

    assign done        = done_reg;
    assign track_error = err_reg;
    assign line_lost   = lost_reg;

endmodule

`default_nettype wire

FILE: design/lpp_pid.sv
// PID stage: error history, clamped integral and a shared multiply-accumulate.
`default_nettype none

module lpp_pid (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lpp_pkg::ERR_W-1:0]  error_in,
    input  logic                              lost_in,
    input  lpp_pkg::gains_t                   gains,
    output logic                              done,
    output logic                              last_positive,
    output logic signed [lpp_pkg::ERR_W-1:0]  track_error,
    output logic                              line_lost,
    output logic signed [lpp_pkg::CORR_W-1:0] steer_correction
);

    localparam int DIFF_W = lpp_pkg::ERR_W + 2;
    localparam int SUMW_W = lpp_pkg::ERR_W + 1;
    localparam int PROD_W = lpp_pkg::GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = PROD_W + 1;

    typedef enum logic [3:0] {
        MAC_PROP  = 4'b0001,
        MAC_INTEG = 4'b0010,
        MAC_DERIV = 4'b0100,
        MAC_FLUSH = 4'b1000
    } mac_step_t;

    logic signed [lpp_pkg::ERR_W-1:0] last_error_reg, last_error_next;
    logic signed [lpp_pkg::ERR_W-1:0] error_sum_reg, error_sum_next;
    logic signed [SUMW_W-1:0]         sum_wide;
    logic signed [DIFF_W-1:0]         diff;
    logic signed [lpp_pkg::ERR_W-1:0] err_reg;
    logic signed [lpp_pkg::ERR_W-1:0] isum_reg;
    logic signed [DIFF_W-1:0]         diff_reg;
    logic                             lost_reg;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    mac_step_t                        step_reg, step_next;
    logic [lpp_pkg::GAIN_W-1:0]       op_gain;
    logic signed [DIFF_W-1:0]         op_val;
    logic signed [PROD_W-1:0]         product;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;

    // Derivative term and clamped integral
    always_comb
    begin
        diff     = DIFF_W'(error_in) - DIFF_W'(last_error_reg);
        sum_wide = SUMW_W'(error_sum_reg) + SUMW_W'(error_in);
        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        if (start)
        begin
            last_error_next = error_in;
            if (sum_wide > SUMW_W'(lpp_pkg::SUM_LIMIT))
                error_sum_next = lpp_pkg::SUM_LIMIT;
            else if (sum_wide < -SUMW_W'(lpp_pkg::SUM_LIMIT))
                error_sum_next = -lpp_pkg::SUM_LIMIT;
            else
                error_sum_next = sum_wide[lpp_pkg::ERR_W-1:0];
        end
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

    // Operands held for the multiply sequence
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            err_reg  <= error_in;
            isum_reg <= error_sum_next;
            diff_reg <= diff;
            lost_reg <= lost_in;
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            MAC_PROP:
            begin
                op_gain = gains.prop_gain;
                op_val  = DIFF_W'(err_reg);
            end
            MAC_INTEG:
            begin
                op_gain = gains.integ_gain;
                op_val  = DIFF_W'(isum_reg);
            end
            MAC_DERIV:
            begin
                op_gain = gains.deriv_gain;
                op_val  = diff_reg;
            end
            default:
            begin
                op_gain = '0;
                op_val  = '0;
            end
        endcase
        product = PROD_W'($signed({1'b0, op_gain}) * op_val);
    end

    // Sequencer: product registered, accumulated one step later
    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (start)
        begin
            step_next = MAC_PROP;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                MAC_PROP:
                    step_next = MAC_INTEG;
                MAC_INTEG:
                begin
                    step_next = MAC_DERIV;
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                end
                MAC_DERIV:
                begin
                    step_next = MAC_FLUSH;
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                end
                MAC_FLUSH:
                begin
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MAC_PROP;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        acc_reg  <= acc_next;
    end

    // Floor shift; with 16-bit gains the sum stays well inside 32 bits,
    // so the narrowing never has to saturate
    assign steer_correction = lpp_pkg::CORR_W'(acc_reg >>> lpp_pkg::FRAC_W);
    assign done             = done_reg;
    assign last_positive    = (last_error_reg > 0);
    assign track_error      = err_reg;
    assign line_lost        = lost_reg;

endmodule

`default_nettype wire

FILE: design/lpp_checker.sv
// Port-level checks for the line position PID block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module lpp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [lpp_pkg::ERR_W-1:0]  track_error,
    input logic signed [lpp_pkg::CORR_W-1:0] steer_correction,
    input logic                              line_lost
);

    // A stalled result keeps its correction value
    `LPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(steer_correction), "stalled result changed")

    // One item at a time: the input closes right after a transfer
    `LPP_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "input open while an item is in flight")

    // Track error stays within plus or minus thirty
    `LPP_ASSERT_IMP(a_error_range, clk, rst_n, out_valid, (track_error <= 14'sd7680) && (track_error >= -14'sd7680), "track error out of range")

    // A lost line reports the fixed recovery error
    `LPP_ASSERT_IMP(a_lost_error, clk, rst_n, out_valid && line_lost, (track_error == 14'sd6400) || (track_error == -14'sd6400), "lost line error not plus or minus 25")

endmodule

bind line_position_pid lpp_checker u_lpp_checker (.*);

`default_nettype wire
